// ===== hw/rtl/command_frame_receiver_macros.svh =====
// Assertion macros shared by the command frame receiver RTL.
// Included by each module that carries concurrent assertions; needs no other file.
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define CFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("command frame receiver: same-cycle check failed");
`define CFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("command frame receiver: next-cycle check failed");
`else
`define CFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/cfr_pkg.sv =====
// Shared constants, types and the letter decoder of the command frame receiver.
// Has no dependencies; every RTL module of the block imports it.
`default_nettype none
package cfr_pkg;

	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_T       = 8'h74;
	localparam logic [7:0] CHAR_P       = 8'h70;
	localparam logic [7:0] CHAR_S       = 8'h73;
	localparam logic [7:0] CHAR_C       = 8'h63;
	localparam logic [7:0] CHAR_R       = 8'h72;
	localparam logic [7:0] CHAR_W       = 8'h77;

	localparam int CODE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int BYTE_W  = 8;
	localparam int POS_W   = 3;

	localparam logic [CODE_W-1:0] CMD_TIME   = 3'd0;
	localparam logic [CODE_W-1:0] CMD_POWER  = 3'd1;
	localparam logic [CODE_W-1:0] CMD_SLEEP  = 3'd2;
	localparam logic [CODE_W-1:0] CMD_C      = 3'd3;
	localparam logic [CODE_W-1:0] CMD_REBOOT = 3'd4;
	localparam logic [CODE_W-1:0] CMD_WAKEUP = 3'd5;

	localparam logic [POS_W-1:0] POS_LETTER = 3'd0;
	localparam logic [POS_W-1:0] POS_COLON  = 3'd1;
	localparam logic [POS_W-1:0] POS_DATA0  = 3'd2;
	localparam logic [POS_W-1:0] POS_DATA1  = 3'd3;
	localparam logic [POS_W-1:0] POS_DATA2  = 3'd4;
	localparam logic [POS_W-1:0] POS_DATA3  = 3'd5;
	localparam logic [POS_W-1:0] POS_END    = 3'd6;

	typedef struct packed {
		logic              ok;
		logic [CODE_W-1:0] code;
	} letter_t;

	typedef struct packed {
		logic               fire;
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] power;
		logic [VALUE_W-1:0] sleep;
		logic [VALUE_W-1:0] reboot;
		logic [VALUE_W-1:0] wakeup;
	} result_t;

	function automatic letter_t decode_letter(input logic [BYTE_W-1:0] b);
		letter_t l;
		l.ok = 1'b1;
		l.code = CMD_TIME;
		case (b)
			CHAR_T: l.code = CMD_TIME;
			CHAR_P: l.code = CMD_POWER;
			CHAR_S: l.code = CMD_SLEEP;
			CHAR_C: l.code = CMD_C;
			CHAR_R: l.code = CMD_REBOOT;
			CHAR_W: l.code = CMD_WAKEUP;
			default: l.ok = 1'b0;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cfr_in_reg.sv =====
// Input register of the command frame receiver: holds one received byte.
// Depends on cfr_pkg.
`default_nettype none
module cfr_in_reg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [cfr_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                      take,
	output logic                           valid_s1,
	output logic [cfr_pkg::BYTE_W-1:0]     byte_s1
);
	import cfr_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cfr_framer.sv =====
// Frame tracker and setting registers of the command frame receiver.
// Depends on cfr_pkg and command_frame_receiver_macros.svh.
`default_nettype none
`include "command_frame_receiver_macros.svh"
module cfr_framer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [cfr_pkg::BYTE_W-1:0] byte_s1,
	output cfr_pkg::result_t                res
);
	import cfr_pkg::*;

	logic [POS_W-1:0]   pos_q, pos_d;
	logic [CODE_W-1:0]  pend_q, pend_d;
	logic [VALUE_W-1:0] shift_q, shift_d;
	logic [VALUE_W-1:0] power_q, sleep_q, reboot_q, wakeup_q;
	letter_t            letter;

	assign letter = decode_letter(byte_s1);

	always_comb begin
		pos_d = pos_q;
		pend_d = pend_q;
		shift_d = shift_q;
		res.fire = 1'b0;
		res.code = pend_q;
		res.value = shift_q;
		res.power = power_q;
		res.sleep = sleep_q;
		res.reboot = reboot_q;
		res.wakeup = wakeup_q;
		case (pos_q)
			POS_COLON: begin
				pos_d = (byte_s1 == CHAR_COLON) ? POS_DATA0 : POS_LETTER;
			end
			POS_DATA0, POS_DATA1, POS_DATA2, POS_DATA3: begin
				shift_d = {shift_q[VALUE_W-BYTE_W-1:0], byte_s1};
				pos_d = pos_q + 3'd1;
			end
			POS_END: begin
				pos_d = POS_LETTER;
				if (byte_s1 == CHAR_NEWLINE) begin
					res.fire = 1'b1;
					case (pend_q)
						CMD_POWER:  res.power = shift_q;
						CMD_SLEEP:  res.sleep = shift_q;
						CMD_REBOOT: res.reboot = shift_q;
						CMD_WAKEUP: res.wakeup = shift_q;
						default: ;
					endcase
				end
			end
			default: begin
				if (letter.ok) begin
					pend_d = letter.code;
					shift_d = '0;
					pos_d = POS_COLON;
				end else begin
					pos_d = POS_LETTER;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_LETTER;
			pend_q <= CMD_TIME;
			shift_q <= '0;
			power_q <= '0;
			sleep_q <= '0;
			reboot_q <= '0;
			wakeup_q <= '0;
		end else if (step) begin
			pos_q <= pos_d;
			pend_q <= pend_d;
			shift_q <= shift_d;
			power_q <= res.power;
			sleep_q <= res.sleep;
			reboot_q <= res.reboot;
			wakeup_q <= res.wakeup;
		end
	end

	`CFR_ASSERT_SAME(a_pos_in_range, clk, arst_n, 1'b1, pos_q != 3'd7)
	`CFR_ASSERT_NEXT(a_end_restarts, clk, arst_n, step && pos_q == POS_END, pos_q == POS_LETTER)
	`CFR_ASSERT_NEXT(a_settings_hold, clk, arst_n, !(step && res.fire),
		$stable(power_q) && $stable(sleep_q) && $stable(reboot_q) && $stable(wakeup_q))

endmodule
`default_nettype wire

// ===== hw/rtl/cfr_out_reg.sv =====
// Result register of the command frame receiver: holds one finished frame beat.
// Depends on cfr_pkg.
`default_nettype none
module cfr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire cfr_pkg::result_t res,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output cfr_pkg::result_t      res_q
);
	import cfr_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= res.fire;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.fire) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/command_frame_receiver.sv =====
// Command frame receiver: one byte register, the frame tracker, one result register.
// Byte beat to result beat: byte register, then result register. One byte is taken
// per cycle; bytes stall only while a finished result is held and output not ready.
// Asynchronous active-low reset clears position, command, value and all settings.
// Depends on cfr_pkg, cfr_in_reg, cfr_framer, cfr_out_reg and the macros header.
`default_nettype none
`include "command_frame_receiver_macros.svh"
module command_frame_receiver (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [cfr_pkg::BYTE_W-1:0]  rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [cfr_pkg::CODE_W-1:0]       command_code,
	output logic [cfr_pkg::VALUE_W-1:0]      frame_value,
	output logic [cfr_pkg::VALUE_W-1:0]      power_period_out,
	output logic [cfr_pkg::VALUE_W-1:0]      sleep_period_out,
	output logic [cfr_pkg::VALUE_W-1:0]      reboot_limit_out,
	output logic [cfr_pkg::VALUE_W-1:0]      wakeup_time_out
);
	import cfr_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              take;
	result_t           res;
	result_t           res_q;

	assign take = valid_s1 && (!out_valid || out_ready);

	cfr_in_reg u_in (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.rx_byte(rx_byte), .take(take), .valid_s1(valid_s1), .byte_s1(byte_s1)
	);

	cfr_framer u_framer (
		.clk(clk), .arst_n(arst_n), .step(take), .byte_s1(byte_s1), .res(res)
	);

	cfr_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .load(take), .res(res), .out_ready(out_ready),
		.out_valid(out_valid), .res_q(res_q)
	);

	assign command_code = res_q.code;
	assign frame_value = res_q.value;
	assign power_period_out = res_q.power;
	assign sleep_period_out = res_q.sleep;
	assign reboot_limit_out = res_q.reboot;
	assign wakeup_time_out = res_q.wakeup;

	`CFR_ASSERT_SAME(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && out_valid && !out_ready)
	`CFR_ASSERT_NEXT(a_no_result_idle, clk, arst_n, !valid_s1 && (!out_valid || out_ready),
		!out_valid)

endmodule
`default_nettype wire

// ===== tb/sv/command_frame_receiver_test.sv =====
// Self-checking testbench for the command frame receiver: seven-byte frames, settings, results.
// Feeds directed then random byte streams under varying back-pressure and predicts every result.
// Depends on cfr_pkg and the command_frame_receiver RTL only.
module command_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cfr_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 11;
	localparam int STIM_BYTES   = 1800;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] power;
		logic [VALUE_W-1:0] sleep;
		logic [VALUE_W-1:0] reboot;
		logic [VALUE_W-1:0] wakeup;
	} frame_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CODE_W-1:0]   command_code;
	logic [VALUE_W-1:0]  frame_value;
	logic [VALUE_W-1:0]  power_period_out;
	logic [VALUE_W-1:0]  sleep_period_out;
	logic [VALUE_W-1:0]  reboot_limit_out;
	logic [VALUE_W-1:0]  wakeup_time_out;

	logic [BYTE_W-1:0]   byte_backlog[$];
	frame_result_t       expected_frames[$];
	int                  stim_total      = 0;
	int                  framed_bytes    = 0;
	int                  bytes_sent      = 0;
	int                  results_checked = 0;
	int                  mismatches      = 0;
	int                  quiet_cycles    = 0;
	int                  results_by_code[6] = '{default: 0};

	logic [POS_W-1:0]    frame_pos  = POS_LETTER;
	logic [CODE_W-1:0]   held_code  = CMD_TIME;
	logic [VALUE_W-1:0]  value_acc  = '0;
	logic [VALUE_W-1:0]  power_reg  = '0;
	logic [VALUE_W-1:0]  sleep_reg  = '0;
	logic [VALUE_W-1:0]  reboot_reg = '0;
	logic [VALUE_W-1:0]  wakeup_reg = '0;

	always #(CLK_PERIOD/2) clk = ~clk;

	command_frame_receiver u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.command_code     (command_code),
		.frame_value      (frame_value),
		.power_period_out (power_period_out),
		.sleep_period_out (sleep_period_out),
		.reboot_limit_out (reboot_limit_out),
		.wakeup_time_out  (wakeup_time_out)
	);

	function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
		frame_result_t     r;
		logic              letter_ok;
		logic [CODE_W-1:0] code;
		letter_ok = 1'b1;
		code = CMD_TIME;
		case (frame_pos)
			POS_COLON: begin
				frame_pos = (b == CHAR_COLON) ? POS_DATA0 : POS_LETTER;
			end
			POS_DATA0, POS_DATA1, POS_DATA2, POS_DATA3: begin
				value_acc = {value_acc[VALUE_W-BYTE_W-1:0], b};
				frame_pos = frame_pos + 1'b1;
			end
			POS_END: begin
				frame_pos = POS_LETTER;
				if (b == CHAR_NEWLINE) begin
					case (held_code)
						CMD_POWER:  power_reg  = value_acc;
						CMD_SLEEP:  sleep_reg  = value_acc;
						CMD_REBOOT: reboot_reg = value_acc;
						CMD_WAKEUP: wakeup_reg = value_acc;
						default: ;
					endcase
					r.code   = held_code;
					r.value  = value_acc;
					r.power  = power_reg;
					r.sleep  = sleep_reg;
					r.reboot = reboot_reg;
					r.wakeup = wakeup_reg;
					expected_frames.push_back(r);
				end
			end
			default: begin
				case (b)
					CHAR_T:  code = CMD_TIME;
					CHAR_P:  code = CMD_POWER;
					CHAR_S:  code = CMD_SLEEP;
					CHAR_C:  code = CMD_C;
					CHAR_R:  code = CMD_REBOOT;
					CHAR_W:  code = CMD_WAKEUP;
					default: letter_ok = 1'b0;
				endcase
				if (letter_ok) begin
					held_code = code;
					value_acc = '0;
					frame_pos = POS_COLON;
				end else begin
					frame_pos = POS_LETTER;
				end
			end
		endcase
	endfunction

	function automatic void log_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
	endfunction

	function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got)
			log_mismatch($sformatf("%s expected %h, got %h", name, want, got));
	endfunction

	function automatic void queue_frame(input logic [BYTE_W-1:0] letter,
			input logic [BYTE_W-1:0] colon, input logic [VALUE_W-1:0] value,
			input logic [BYTE_W-1:0] tail);
		byte_backlog.push_back(letter);
		byte_backlog.push_back(colon);
		for (int i = 3; i >= 0; i--)
			byte_backlog.push_back(value[8*i +: 8]);
		byte_backlog.push_back(tail);
		framed_bytes += 7;
	endfunction

	// The run falls into three equal thirds by bytes sent, each with its own idling mix.
	function automatic int idle_phase();
		if (bytes_sent * 3 < stim_total)
			return 0;
		else if (bytes_sent * 3 < stim_total * 2)
			return 1;
		return 2;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_bytes
		int sender_idle_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_byte(rx_byte);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				case (idle_phase())
					0:       sender_idle_pct = 30;
					1:       sender_idle_pct = 71;
					default: sender_idle_pct = 0;
				endcase
				if (byte_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= byte_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		frame_result_t want;
		int            receiver_idle_pct;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					log_mismatch($sformatf("unexpected result, code %0d value %h",
						command_code, frame_value));
				end else begin
					want = expected_frames.pop_front();
					check_field("command_code", VALUE_W'(want.code), VALUE_W'(command_code));
					check_field("frame_value", want.value, frame_value);
					check_field("power_period_out", want.power, power_period_out);
					check_field("sleep_period_out", want.sleep, sleep_period_out);
					check_field("reboot_limit_out", want.reboot, reboot_limit_out);
					check_field("wakeup_time_out", want.wakeup, wakeup_time_out);
					results_checked++;
					if (want.code <= CMD_WAKEUP)
						results_by_code[want.code]++;
				end
			end
			case (idle_phase())
				0:       receiver_idle_pct = 71;
				1:       receiver_idle_pct = 30;
				default: receiver_idle_pct = 0;
			endcase
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : run_sequence
		logic [BYTE_W-1:0]  letters[6];
		logic [BYTE_W-1:0]  letter;
		logic [VALUE_W-1:0] value;
		int                 kind;
		int                 cut;
		letters[0] = CHAR_T;
		letters[1] = CHAR_P;
		letters[2] = CHAR_S;
		letters[3] = CHAR_C;
		letters[4] = CHAR_R;
		letters[5] = CHAR_W;

		// Every command once, with extreme data and newline and colon bytes inside the data.
		queue_frame(CHAR_P, CHAR_COLON, 32'hFFFF_FFFF, CHAR_NEWLINE);
		queue_frame(CHAR_S, CHAR_COLON, 32'h0000_0000, CHAR_NEWLINE);
		queue_frame(CHAR_R, CHAR_COLON, 32'h0A0A_0A0A, CHAR_NEWLINE);
		queue_frame(CHAR_W, CHAR_COLON, 32'h3A74_FF00, CHAR_NEWLINE);
		queue_frame(CHAR_T, CHAR_COLON, 32'h8000_0001, CHAR_NEWLINE);
		queue_frame(CHAR_C, CHAR_COLON, 32'h7F0A_0A01, CHAR_NEWLINE);
		// Bytes that are no command letter are dropped at the start of a frame.
		byte_backlog.push_back(8'h00);
		byte_backlog.push_back(8'hFF);
		byte_backlog.push_back(8'h50);
		// A letter where the colon belongs aborts the frame and is not taken as a new letter.
		byte_backlog.push_back(CHAR_P);
		byte_backlog.push_back(CHAR_P);
		// A letter where the newline belongs drops the frame without a result.
		queue_frame(CHAR_R, CHAR_COLON, 32'h1234_5678, CHAR_T);
		queue_frame(CHAR_S, CHAR_COLON, 32'hC0DE_0A55, CHAR_NEWLINE);

		// Mostly well-formed frames with random content, the rest broken frames and noise.
		while (framed_bytes < STIM_BYTES) begin
			kind = $urandom_range(0, 99);
			letter = letters[$urandom_range(0, 5)];
			case ($urandom_range(0, 9))
				0:       value = '0;
				1:       value = '1;
				2: begin
					value = $urandom;
					value[8*$urandom_range(0, 3) +: 8] = CHAR_NEWLINE;
				end
				default: value = $urandom;
			endcase
			if (kind < 72) begin
				queue_frame(letter, CHAR_COLON, value, CHAR_NEWLINE);
			end else if (kind < 80) begin
				queue_frame(letter, BYTE_W'($urandom_range(0, 255)), value, CHAR_NEWLINE);
			end else if (kind < 88) begin
				queue_frame(letter, CHAR_COLON, value, BYTE_W'($urandom_range(0, 255)));
			end else if (kind < 93) begin
				cut = $urandom_range(0, 3);
				byte_backlog.push_back(letter);
				byte_backlog.push_back(CHAR_COLON);
				for (int i = 0; i < cut; i++)
					byte_backlog.push_back(value[8*i +: 8]);
				framed_bytes += 2 + cut;
			end else begin
				repeat ($urandom_range(1, 4))
					byte_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
			end
		end
		stim_total = byte_backlog.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!(byte_backlog.size() == 0 && !in_valid && expected_frames.size() == 0)
				&& quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		if (quiet_cycles >= QUIET_LIMIT) begin
			mismatches++;
			$display("Timeout: no beat for %0d cycles, %0d bytes unsent, %0d results outstanding.",
				quiet_cycles, byte_backlog.size(), expected_frames.size());
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
		end
		if (expected_frames.size() > 0) begin
			log_mismatch($sformatf("%0d expected results never arrived", expected_frames.size()));
			mismatches += expected_frames.size() - 1;
		end

		$display("Sent %0d bytes across three back-pressure mixes; checked %0d frame results.",
			bytes_sent, results_checked);
		$display("Results per command t/p/s/c/r/w: %0d %0d %0d %0d %0d %0d; mismatches: %0d.",
			results_by_code[0], results_by_code[1], results_by_code[2], results_by_code[3],
			results_by_code[4], results_by_code[5], mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
